/* src/icmpcs_pkg.sv */
// ----------------------------------------------------------------------------
// icmpcs_pkg: shared types and constants
// Mode codes and IPv6 header layout constants for the checksum streamer.
// ----------------------------------------------------------------------------
`default_nettype none

package icmpcs_pkg;

  typedef enum logic {
    MODE_PLAIN  = 1'b0,
    MODE_ICMPV6 = 1'b1
  } mode_e;

  // IPv6 header length in 16-bit words
  localparam int HeaderWords = 20;
  localparam int IdxW        = $clog2(HeaderWords + 1);

  // header word positions
  localparam int LenWordIdx    = 2;
  localparam int NhWordIdx     = 3;
  localparam int AddrWordFirst = 4;

  localparam logic [15:0] NextHeaderIcmpv6 = 16'd58;

endpackage

`default_nettype wire

/* src/icmpv6_internet_checksum.sv */
// ----------------------------------------------------------------------------
// icmpv6_internet_checksum: streaming Internet / ICMPv6 checksum
// Ones'-complement sum of a 16-bit word stream, with optional ICMPv6
// pseudo-header selection over an IPv6 packet.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                  | tuser        | tlast
//  s_axis   | in        | [15:0] word            | single_byte  | last
//  m_axis   | out       | [15:0] checksum        | truncated    | -
//  cfg      | in        | cfg_wdata_i: mode      | -            | -
//
//  One word per cycle while the input is not stalled. A word is registered at
//  the input, summed from that register and, if it is the last one, its result
//  lands in the output register, which drives m_axis_tvalid.
//  Input stalls only when a last word waits for an output register still held
//  by m_axis_tready low. Reset clears mode, sum and packet state.
// ----------------------------------------------------------------------------
`default_nettype none

module icmpv6_internet_checksum (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,   // mode
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] word
  input  wire logic        s_axis_tuser,  // [0] single_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // [15:0] checksum
  output logic             m_axis_tuser   // [0] truncated
);
  import icmpcs_pkg::*;

  mode_e            mode_q;
  logic             in_valid_q;
  logic [15:0]      in_word_q;
  logic             in_single_q;
  logic             in_last_q;
  logic [15:0]      acc_q, acc_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [15:0]      bytes_q, bytes_d;
  logic             out_valid_q;
  logic [15:0]      out_csum_q;
  logic             out_trunc_q;

  logic             advance;
  logic [15:0]      word_m;
  logic [15:0]      addend;
  logic             add_en;
  logic             trunc_hdr;
  logic             trunc;
  logic [16:0]      sum;

  // a non-last word never needs the output register
  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign word_m = in_single_q ? {in_word_q[15:8], 8'h00} : in_word_q;

  always_comb begin
    add_en    = 1'b0;
    addend    = word_m;
    trunc_hdr = 1'b0;
    bytes_d   = bytes_q;
    if (mode_q == MODE_PLAIN) begin
      add_en = 1'b1;
    end else if (idx_q < IdxW'(HeaderWords)) begin
      if (idx_q == IdxW'(LenWordIdx)) begin
        bytes_d = word_m;
        add_en  = 1'b1;
      end else if (idx_q == IdxW'(NhWordIdx)) begin
        addend = NextHeaderIcmpv6;
        add_en = 1'b1;
      end else if (idx_q >= IdxW'(AddrWordFirst)) begin
        add_en = 1'b1;
      end
      trunc_hdr = in_last_q && ((idx_q < IdxW'(HeaderWords - 1)) || in_single_q);
    end else if (bytes_q != 16'd0) begin
      add_en = 1'b1;
      if (bytes_q == 16'd1) begin
        // odd payload tail: only the upper byte counts
        addend  = {word_m[15:8], 8'h00};
        bytes_d = 16'd0;
      end else begin
        bytes_d = bytes_q - (in_single_q ? 16'd1 : 16'd2);
      end
    end
  end

  // end-around carry add
  assign sum   = {1'b0, acc_q} + {1'b0, addend};
  assign acc_d = add_en ? (sum[15:0] + {15'd0, sum[16]}) : acc_q;
  assign trunc = trunc_hdr || ((mode_q == MODE_ICMPV6) && (bytes_d != 16'd0));

  // index saturates once past the header
  assign idx_d = (idx_q < IdxW'(HeaderWords)) ? idx_q + IdxW'(1) : idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_PLAIN;
      in_valid_q  <= 1'b0;
      acc_q       <= '0;
      idx_q       <= '0;
      bytes_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= mode_e'(cfg_wdata_i);
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        if (in_last_q) begin
          acc_q       <= '0;
          idx_q       <= '0;
          bytes_q     <= '0;
          out_valid_q <= 1'b1;
        end else begin
          acc_q   <= acc_d;
          idx_q   <= idx_d;
          bytes_q <= bytes_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_word_q   <= s_axis_tdata;
      in_single_q <= s_axis_tuser;
      in_last_q   <= s_axis_tlast;
    end
    if (advance && in_last_q) begin
      out_csum_q  <= ~acc_d;
      out_trunc_q <= trunc;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_csum_q;
  assign m_axis_tuser  = out_trunc_q;

endmodule

`default_nettype wire

/* src/icmpcs_checker.sv */
// ----------------------------------------------------------------------------
// icmpcs_checker: port-level assertions for the checksum streamer
// Watches the stream and configuration ports over time.
// ----------------------------------------------------------------------------
`default_nettype none

module icmpcs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_we_i,
  input wire logic        cfg_wdata_i,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);
  import icmpcs_pkg::*;

  mode_e mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
    end else if (cfg_we_i) begin
      mode_q <= mode_e'(cfg_wdata_i);
    end
  end

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // the plain checksum never reports a short packet
  a_no_trunc_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (mode_q == MODE_PLAIN) |-> !m_axis_tuser)
    else $error("truncated flag in plain mode");

  // a new result follows a last-word transfer
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result without a last-word transfer");

  // input only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !$past(m_axis_tready && m_axis_tvalid) ||
      m_axis_tvalid)
    else $error("input stalled with no result pending");

endmodule

bind icmpv6_internet_checksum icmpcs_checker u_icmpcs_checker (.*);

`default_nettype wire
